// ----- hdl/fatl_pkg.sv -----
// shared types, codes and defaults of the failed attempt lockout table
package fatl_pkg;

  localparam int unsigned SLOTS_DEFAULT = 8;
  localparam int unsigned USER_W        = 32;
  localparam int unsigned AGE_W         = 32;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned CODE_W        = 3;

  localparam logic [COUNT_W-1:0] MAX_FAIL_RESET = 8'd5;

  typedef enum logic [CODE_W-1:0] {
    OC_MATCH     = 3'd0,
    OC_MISMATCH  = 3'd1,
    OC_NOT_FOUND = 3'd2,
    OC_MISSING   = 3'd3,
    OC_STORAGE   = 3'd4,
    OC_CRYPTO    = 3'd5,
    OC_BAD_PIN   = 3'd6
  } outcome_e;

  typedef enum logic [CODE_W-1:0] {
    RC_SUCCESS   = 3'd0,
    RC_WRONG_PIN = 3'd1,
    RC_LOCKED    = 3'd2,
    RC_INVALID   = 3'd3,
    RC_NOT_FOUND = 3'd4,
    RC_MISSING   = 3'd5,
    RC_STORAGE   = 3'd6,
    RC_CRYPTO    = 3'd7
  } result_e;

  typedef struct packed {
    logic [USER_W-1:0]  user;
    logic [AGE_W-1:0]   age;
    logic [COUNT_W-1:0] fail_count;
    logic               locked;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// ----- hdl/fatl_if.sv -----
// channel interfaces: attempt requests, results and the limit register write
interface fatl_req_if;
  logic                                valid;
  logic                                ready;
  logic [fatl_pkg::USER_W-1:0]         user_id;
  logic [fatl_pkg::CODE_W-1:0]         check_outcome;
  modport source (output valid, output user_id, output check_outcome, input ready);
  modport sink   (input valid, input user_id, input check_outcome, output ready);
endinterface

interface fatl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [fatl_pkg::CODE_W-1:0]         result_code;
  logic [fatl_pkg::COUNT_W-1:0]        failure_count;
  modport source (output valid, output result_code, output failure_count, input ready);
  modport sink   (input valid, input result_code, input failure_count, output ready);
endinterface

interface fatl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fatl_pkg::COUNT_W-1:0]        max_failures;
  modport source (output valid, output max_failures, input ready);
  modport sink   (input valid, input max_failures, output ready);
endinterface

// ----- hdl/fatl_ram.sv -----
// generic single write port ram with registered read
module fatl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fatl_ctrl.sv -----
// scans every slot of a valid attempt, picks match or victim, then updates
module fatl_ctrl #(
  parameter int unsigned SLOTS = fatl_pkg::SLOTS_DEFAULT,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW = $clog2(SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fatl_pkg::COUNT_W-1:0]  max_failures_i,
  fatl_req_if.sink                      req_i,
  fatl_rsp_if.source                    rsp_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output fatl_pkg::slot_t               ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  fatl_pkg::slot_t               ram_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                          state_q;
  logic [fatl_pkg::USER_W-1:0]     uid_q;
  logic [fatl_pkg::CODE_W-1:0]     oc_q;
  logic                            inv_q;
  logic [CW-1:0]                   cnt_q;
  logic                            ev_q;
  logic [AW-1:0]                   ev_idx_q;
  logic                            found_q;
  logic [AW-1:0]                   found_idx_q;
  logic [fatl_pkg::COUNT_W-1:0]    found_cnt_q;
  logic                            found_lock_q;
  logic                            empty_q;
  logic [AW-1:0]                   pick_idx_q;
  logic [fatl_pkg::AGE_W-1:0]      pick_age_q;
  logic [fatl_pkg::AGE_W-1:0]      age_ctr_q;
  logic [SLOTS-1:0]                valid_q;
  logic                            out_valid_q;
  logic [fatl_pkg::CODE_W-1:0]     out_code_q;
  logic [fatl_pkg::COUNT_W-1:0]    out_cnt_q;

  fatl_pkg::slot_t                 ent;
  logic                            accept;
  logic                            req_inv;
  logic                            issue;
  logic                            fire;
  logic [fatl_pkg::AGE_W-1:0]      age_next;
  logic [fatl_pkg::COUNT_W-1:0]    base_cnt;
  logic [fatl_pkg::COUNT_W-1:0]    new_cnt;
  logic                            new_lock;
  logic [fatl_pkg::CODE_W-1:0]     res_code;
  logic [fatl_pkg::COUNT_W-1:0]    res_cnt;
  logic                            wr_en;
  logic [AW-1:0]                   wr_idx;
  logic                            clr_en;
  logic                            bump;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_inv     = (req_i.user_id == '0) ||
                       (req_i.check_outcome >= fatl_pkg::OC_BAD_PIN);

  assign issue       = (state_q == ST_SCAN) && (cnt_q < CW'(SLOTS));
  assign ram_re_o    = issue;
  assign ram_raddr_o = cnt_q[AW-1:0];

  assign ent      = valid_q[ev_idx_q] ? ram_rdata_i : '0;
  assign fire     = (state_q == ST_APPLY) && (!out_valid_q || rsp_o.ready);
  assign age_next = age_ctr_q + 1'b1;
  assign base_cnt = found_q ? found_cnt_q : '0;
  assign new_cnt  = (base_cnt < max_failures_i) ? base_cnt + 1'b1 : base_cnt;
  assign new_lock = (new_cnt >= max_failures_i);

  always_comb begin
    res_code    = fatl_pkg::RC_INVALID;
    res_cnt     = '0;
    wr_en       = 1'b0;
    wr_idx      = found_idx_q;
    clr_en      = 1'b0;
    bump        = 1'b0;
    ram_wdata_o = '{user: uid_q, age: age_next, fail_count: found_cnt_q, locked: 1'b1};
    if (inv_q) begin
      res_code = fatl_pkg::RC_INVALID;
    end else if (found_q && found_lock_q) begin
      res_code = fatl_pkg::RC_LOCKED;
      res_cnt  = found_cnt_q;
      wr_en    = 1'b1;
      bump     = 1'b1;
    end else begin
      unique case (oc_q)
        fatl_pkg::OC_MATCH: begin
          res_code = fatl_pkg::RC_SUCCESS;
          clr_en   = found_q;
        end
        fatl_pkg::OC_MISMATCH: begin
          res_code    = new_lock ? fatl_pkg::RC_LOCKED : fatl_pkg::RC_WRONG_PIN;
          res_cnt     = new_cnt;
          wr_en       = 1'b1;
          wr_idx      = found_q ? found_idx_q : pick_idx_q;
          bump        = 1'b1;
          ram_wdata_o = '{user: uid_q, age: age_next, fail_count: new_cnt,
                          locked: new_lock};
        end
        fatl_pkg::OC_NOT_FOUND: begin
          res_code = fatl_pkg::RC_NOT_FOUND;
          res_cnt  = base_cnt;
        end
        fatl_pkg::OC_MISSING: begin
          res_code = fatl_pkg::RC_MISSING;
          res_cnt  = base_cnt;
        end
        fatl_pkg::OC_STORAGE: begin
          res_code = fatl_pkg::RC_STORAGE;
          res_cnt  = base_cnt;
        end
        fatl_pkg::OC_CRYPTO: begin
          res_code = fatl_pkg::RC_CRYPTO;
          res_cnt  = base_cnt;
        end
        default: begin
          res_code = fatl_pkg::RC_INVALID;
        end
      endcase
    end
  end

  assign ram_we_o    = fire && wr_en;
  assign ram_waddr_o = wr_idx;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_code   = out_code_q;
  assign rsp_o.failure_count = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      uid_q        <= '0;
      oc_q         <= '0;
      inv_q        <= 1'b0;
      cnt_q        <= '0;
      ev_q         <= 1'b0;
      ev_idx_q     <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      found_cnt_q  <= '0;
      found_lock_q <= 1'b0;
      empty_q      <= 1'b0;
      pick_idx_q   <= '0;
      pick_age_q   <= '0;
      age_ctr_q    <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      out_code_q   <= '0;
      out_cnt_q    <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            uid_q   <= req_i.user_id;
            oc_q    <= req_i.check_outcome;
            inv_q   <= req_inv;
            cnt_q   <= '0;
            ev_q    <= 1'b0;
            found_q <= 1'b0;
            empty_q <= 1'b0;
            state_q <= req_inv ? ST_APPLY : ST_SCAN;
          end
        end
        ST_SCAN: begin
          ev_q     <= issue;
          ev_idx_q <= cnt_q[AW-1:0];
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (ev_q) begin
            // first matching slot wins
            if (!found_q && ent.user != '0 && ent.user == uid_q) begin
              found_q      <= 1'b1;
              found_idx_q  <= ev_idx_q;
              found_cnt_q  <= ent.fail_count;
              found_lock_q <= ent.locked;
            end
            // victim: first empty slot, else oldest with lowest index
            if (ev_idx_q == '0) begin
              pick_idx_q <= '0;
              pick_age_q <= ent.age;
              empty_q    <= (ent.user == '0);
            end else if (!empty_q) begin
              if (ent.user == '0) begin
                empty_q    <= 1'b1;
                pick_idx_q <= ev_idx_q;
              end else if (ent.age < pick_age_q) begin
                pick_idx_q <= ev_idx_q;
                pick_age_q <= ent.age;
              end
            end
            if (!issue) begin
              state_q <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (fire) begin
            out_code_q  <= res_code;
            out_cnt_q   <= res_cnt;
            if (bump) begin
              age_ctr_q <= age_next;
            end
            if (wr_en) begin
              valid_q[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
              valid_q[found_idx_q] <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/failed_attempt_lockout_table_top.sv -----
// top level of the failed attempt lockout table
//
// req_i takes one login attempt per item: a user id and the outcome of the
// external credential check. rsp_o returns one result item per attempt with
// the result code and the user's failure count. cfg_i, always ready, writes
// max_failures, by the user only while the block is idle; nothing enforces it.
//
// An attempt walks all SLOTS entries of the slot ram, one read a cycle through
// the registered read port, then the apply state applies the update and loads
// the result register; an invalid attempt skips the walk. req_i is ready only
// between attempts, so a new attempt is taken only after the last is applied.
//
// A finished result sits in the output register; a new attempt is taken and
// walked while it waits, and the update of that attempt holds until the
// receiver takes the earlier result. Reset empties all slots at once through
// per-slot valid bits, clears the age counter and sets max_failures to 5.
module failed_attempt_lockout_table_top #(
  parameter int unsigned SLOTS = fatl_pkg::SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fatl_req_if.sink    req_i,
  fatl_rsp_if.source  rsp_o,
  fatl_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [fatl_pkg::COUNT_W-1:0] max_fail_q;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  fatl_pkg::slot_t              ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [fatl_pkg::SLOT_W-1:0]  ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fail_q <= fatl_pkg::MAX_FAIL_RESET;
    end else if (cfg_i.valid) begin
      max_fail_q <= cfg_i.max_failures;
    end
  end

  fatl_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_failures_i (max_fail_q),
    .req_i          (req_i),
    .rsp_o          (rsp_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (fatl_pkg::slot_t'(ram_rdata))
  );

  fatl_ram #(
    .WIDTH (fatl_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("attempt accepted while previous one still in flight");

  a_wrong_pin_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.result_code == fatl_pkg::RC_WRONG_PIN) |->
    (rsp_o.failure_count != '0))
    else $error("wrong pin result with zero failure count");

  a_zero_count_codes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.result_code == fatl_pkg::RC_INVALID ||
                     rsp_o.result_code == fatl_pkg::RC_SUCCESS)) |->
    (rsp_o.failure_count == '0))
    else $error("success or invalid result with nonzero failure count");

  a_no_ram_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("slot write overlaps slot walk");

endmodule
